// ===== hw/rtl/iplr_pkg.sv =====
// shared types, constants and helpers for the ipv6 longest prefix route table
package iplr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HALF_W      = 64;
  localparam int ADDR_W      = 2 * HALF_W;
  localparam int LEN_W       = 8;
  localparam int PORT_W      = 32;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(ADDR_W);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_QUERY  = 2'd3
  } req_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  // one table slot; mask is kept so the scan needs no shifter
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] nexthop;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    req_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } key_t;

  typedef struct packed {
    logic             hit_vld;
    logic [LEN_W-1:0] best_len;
  } scan_state_t;

  // top len bits set, len already saturated to 128
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

// ===== hw/rtl/iplr_req_if.sv =====
// request channel: valid/ready handshake with one request word
interface iplr_req_if import iplr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [HALF_W-1:0] addr_hi;
  logic [HALF_W-1:0] addr_lo;
  logic [LEN_W-1:0]  pfx_len;
  logic [HALF_W-1:0] nexthop_hi;
  logic [HALF_W-1:0] nexthop_lo;
  logic [PORT_W-1:0] intf_id;

  modport source (
    output valid, req_type, addr_hi, addr_lo, pfx_len, nexthop_hi, nexthop_lo, intf_id,
    input  ready
  );

  modport sink (
    input  valid, req_type, addr_hi, addr_lo, pfx_len, nexthop_hi, nexthop_lo, intf_id,
    output ready
  );

endinterface

// ===== hw/rtl/iplr_rsp_if.sv =====
// response channel: valid/ready handshake with one result word
interface iplr_rsp_if import iplr_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              found;
  logic              table_full;
  logic [HALF_W-1:0] out_addr_hi;
  logic [HALF_W-1:0] out_addr_lo;
  logic [LEN_W-1:0]  out_pfx_len;
  logic [HALF_W-1:0] out_nexthop_hi;
  logic [HALF_W-1:0] out_nexthop_lo;
  logic [PORT_W-1:0] out_intf_id;

  modport source (
    output valid, found, table_full, out_addr_hi, out_addr_lo, out_pfx_len,
           out_nexthop_hi, out_nexthop_lo, out_intf_id,
    input  ready
  );

  modport sink (
    input  valid, found, table_full, out_addr_hi, out_addr_lo, out_pfx_len,
           out_nexthop_hi, out_nexthop_lo, out_intf_id,
    output ready
  );

endinterface

// ===== hw/rtl/iplr_cmp.sv =====
// shared compare unit: decides whether the slot under scan becomes the hit
module iplr_cmp import iplr_pkg::*; (
  input  key_t        key,
  input  entry_t      ent,
  input  logic        slot_valid,
  input  scan_state_t scan,
  output logic        take_hit
);

  logic pm;
  logic len_eq;
  logic addr_eq;

  // entry mask equals key mask whenever lengths agree
  assign pm      = ((ent.addr ^ key.addr) & ent.mask) == '0;
  assign len_eq  = ent.len == key.len;
  assign addr_eq = ent.addr == key.addr;

  always_comb begin
    unique case (key.op)
      OP_INSERT, OP_DELETE: take_hit = slot_valid && !scan.hit_vld && len_eq && pm;
      OP_LOOKUP:            take_hit = slot_valid && pm &&
                                       (!scan.hit_vld || ent.len > scan.best_len);
      OP_QUERY:             take_hit = slot_valid && !scan.hit_vld && len_eq && addr_eq;
      default:              take_hit = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/ipv6_longest_prefix_route_table_unit.sv =====
// ipv6 longest prefix route table: linear scan over a table memory with separate write and read ports
// a request is taken only in the idle state, after the last one finishes; one slot read and compared per cycle
// the result register lets the next request be taken while a result waits
// reset clears the slot valid bits at once (table empty); no clearing pass
module ipv6_longest_prefix_route_table_unit import iplr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  iplr_req_if.sink    req,
  iplr_rsp_if.source  rsp
);

  state_t            state, state_next;
  logic              in_ready;
  logic              finish;
  logic              accept;
  logic              out_free;

  logic [IDX_W-1:0]  idx;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data;
  logic [TABLE_DEPTH-1:0] valid;

  key_t              key;
  logic [ADDR_W-1:0] key_mask;
  logic [ADDR_W-1:0] key_nexthop;
  logic [PORT_W-1:0] key_port;
  logic [LEN_W-1:0]  len_sat;

  scan_state_t       scan;
  logic [IDX_W-1:0]  hit_idx;
  logic              free_vld;
  logic [IDX_W-1:0]  free_idx;
  entry_t            hold;

  logic              slot_valid;
  logic              cmp_hit;
  logic              take_hit;
  logic              take_free;

  logic              mem_we;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            wr_data;
  logic              del_hit;
  logic              res_found;
  logic              res_full;

  logic              out_valid;
  logic              out_found;
  logic              out_full;
  entry_t            out_ent;

  // fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx == LAST_IDX) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;
  assign out_free  = !out_valid || rsp.ready;

  // request capture
  assign len_sat = (req.pfx_len > MAX_LEN) ? MAX_LEN : req.pfx_len;

  always_ff @(posedge clk) begin
    if (accept) begin
      key.op      <= req_op_t'(req.req_type);
      key.addr    <= {req.addr_hi, req.addr_lo};
      key.len     <= len_sat;
      key_mask    <= prefix_mask(len_sat);
      key_nexthop <= {req.nexthop_hi, req.nexthop_lo};
      key_port    <= req.intf_id;
    end
  end

  // table memory, registered read
  assign wr_data = '{addr: key.addr, mask: key_mask, len: key.len,
                     nexthop: key_nexthop, port: key_port};

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= wr_data;
    rd_data <= mem[idx];
  end

  // scan counter and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= (state == ST_SCAN);
      if (state == ST_SCAN) idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx;
  end

  assign slot_valid = valid[cmp_idx];

  iplr_cmp u_cmp (
    .key        (key),
    .ent        (rd_data),
    .slot_valid (slot_valid),
    .scan       (scan),
    .take_hit   (cmp_hit)
  );

  assign take_hit  = cmp_vld && cmp_hit;
  assign take_free = cmp_vld && !slot_valid && !free_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.hit_vld  <= 1'b0;
      scan.best_len <= '0;
      free_vld      <= 1'b0;
    end else if (accept) begin
      scan.hit_vld <= 1'b0;
      free_vld     <= 1'b0;
    end else begin
      if (take_hit) begin
        scan.hit_vld  <= 1'b1;
        scan.best_len <= rd_data.len;
      end
      if (take_free) free_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx <= cmp_idx;
      hold    <= rd_data;
    end
    if (take_free) free_idx <= cmp_idx;
  end

  // table update at the end of the scan
  assign wr_idx  = scan.hit_vld ? hit_idx : free_idx;
  assign mem_we  = finish && (key.op == OP_INSERT) && (scan.hit_vld || free_vld);
  assign del_hit = finish && (key.op == OP_DELETE) && scan.hit_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[wr_idx] <= 1'b1;
    end else if (del_hit) begin
      valid[hit_idx] <= 1'b0;
    end
  end

  // result register
  assign res_found = ((key.op == OP_LOOKUP) || (key.op == OP_QUERY)) && scan.hit_vld;
  assign res_full  = (key.op == OP_INSERT) && !scan.hit_vld && !free_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_found <= res_found;
      out_full  <= res_full;
      out_ent   <= res_found ? hold : '0;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.found          = out_found;
  assign rsp.table_full     = out_full;
  assign rsp.out_addr_hi    = out_ent.addr[ADDR_W-1:HALF_W];
  assign rsp.out_addr_lo    = out_ent.addr[HALF_W-1:0];
  assign rsp.out_pfx_len    = out_ent.len;
  assign rsp.out_nexthop_hi = out_ent.nexthop[ADDR_W-1:HALF_W];
  assign rsp.out_nexthop_lo = out_ent.nexthop[HALF_W-1:0];
  assign rsp.out_intf_id    = out_ent.port;

  // checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_idle_counter_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> idx == '0)
    else $error("scan counter not at slot zero while idle");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result loaded outside the finish step");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    finish && res_full |-> &valid)
    else $error("insert dropped while a slot was free");

  a_compare_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> $past(state == ST_SCAN))
    else $error("compare stage active without a scan read");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the ipv6 longest prefix route table unit
module tb_top;
  import iplr_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    req_op_t     op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  len;
    logic [63:0] nh_hi;
    logic [63:0] nh_lo;
    logic [31:0] port;
  } route_req_t;

  typedef struct packed {
    logic        found;
    logic        table_full;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  len;
    logic [63:0] nh_hi;
    logic [63:0] nh_lo;
    logic [31:0] port;
  } route_rsp_t;

  typedef struct packed {
    logic [127:0] a;
    logic [7:0]   l;
  } route_key_t;

  class route_scoreboard;
    bit           slot_used [TABLE_DEPTH];
    bit [127:0]   slot_addr [TABLE_DEPTH];
    bit [7:0]     slot_len  [TABLE_DEPTH];
    bit [127:0]   slot_hop  [TABLE_DEPTH];
    bit [31:0]    slot_port [TABLE_DEPTH];
    route_rsp_t   expected_q[$];
    int           errors;

    // top n bits set, n at most 128
    static function bit [127:0] len_mask(bit [7:0] n);
      if (n == 0) return '0;
      return {128{1'b1}} << (8'd128 - n);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // apply one accepted request to the shadow table and queue its answer
    function void note_request(route_req_t rq);
      route_rsp_t want;
      bit [127:0] key;
      bit [127:0] m;
      bit [7:0]   n;
      int         hit;
      key  = {rq.addr_hi, rq.addr_lo};
      n    = (rq.len > 8'd128) ? 8'd128 : rq.len;
      m    = len_mask(n);
      want = '0;
      hit  = -1;
      case (rq.op)
        OP_INSERT, OP_DELETE: begin
          for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
            if (slot_used[i] && slot_len[i] == n && ((slot_addr[i] ^ key) & m) == 0) hit = i;
          if (rq.op == OP_DELETE) begin
            if (hit >= 0) slot_used[hit] = 1'b0;
          end else begin
            for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
              if (!slot_used[i]) hit = i;
            if (hit < 0) begin
              want.table_full = 1'b1;
            end else begin
              slot_used[hit] = 1'b1;
              slot_addr[hit] = key;
              slot_len[hit]  = n;
              slot_hop[hit]  = {rq.nh_hi, rq.nh_lo};
              slot_port[hit] = rq.port;
            end
          end
        end
        OP_LOOKUP: begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_used[i] && ((slot_addr[i] ^ key) & len_mask(slot_len[i])) == 0 &&
                (hit < 0 || slot_len[i] > slot_len[hit])) hit = i;
        end
        default: begin
          for (int i = 0; i < TABLE_DEPTH && hit < 0; i++)
            if (slot_used[i] && slot_len[i] == n && slot_addr[i] == key) hit = i;
        end
      endcase
      if ((rq.op == OP_LOOKUP || rq.op == OP_QUERY) && hit >= 0) begin
        want.found = 1'b1;
        {want.addr_hi, want.addr_lo} = slot_addr[hit];
        want.len = slot_len[hit];
        {want.nh_hi, want.nh_lo} = slot_hop[hit];
        want.port = slot_port[hit];
      end
      expected_q.insert(expected_q.size(), want);
    endfunction

    function void compare_field(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v)
        report($sformatf("%s got %h expected %h", name, got_v, want_v));
    endfunction

    function void check_result(route_rsp_t got);
      route_rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with nothing pending, found=%0b", got.found));
        return;
      end
      want = expected_q.pop_front();
      compare_field("found", 64'(got.found), 64'(want.found));
      compare_field("table_full", 64'(got.table_full), 64'(want.table_full));
      compare_field("out_addr_hi", got.addr_hi, want.addr_hi);
      compare_field("out_addr_lo", got.addr_lo, want.addr_lo);
      compare_field("out_pfx_len", 64'(got.len), 64'(want.len));
      compare_field("out_nexthop_hi", got.nh_hi, want.nh_hi);
      compare_field("out_nexthop_lo", got.nh_lo, want.nh_lo);
      compare_field("out_intf_id", 64'(got.port), 64'(want.port));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on = 1'b1;
  int   cycle_count = 0;

  bit [127:0]      prefix_base [8];
  route_key_t      route_pool[$];
  route_scoreboard route_sb = new();

  iplr_req_if req_bus ();
  iplr_rsp_if rsp_bus ();

  ipv6_longest_prefix_route_table_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic bit [7:0] pick_len();
    bit [7:0] corners [7] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd127, 8'd128};
    case ($urandom_range(0, 9))
      0:       return corners[$urandom_range(0, 6)];
      1:       return 8'($urandom_range(129, 255));
      default: return 8'($urandom_range(0, 128));
    endcase
  endfunction

  // keep the first l bits of base, randomize the rest
  function automatic bit [127:0] under_prefix(bit [127:0] base, bit [7:0] l);
    bit [127:0] m;
    m = route_scoreboard::len_mask((l > 8'd128) ? 8'd128 : l);
    return (base & m) | (rand_addr() & ~m);
  endfunction

  function automatic route_req_t route_req(req_op_t op, bit [127:0] a, bit [7:0] l,
                                           bit [127:0] hop, bit [31:0] port);
    route_req_t rq;
    rq.op = op;
    {rq.addr_hi, rq.addr_lo} = a;
    rq.len = l;
    {rq.nh_hi, rq.nh_lo} = hop;
    rq.port = port;
    return rq;
  endfunction

  // mostly routes built on a few shared prefixes so lookups nest and hit
  function automatic route_req_t make_route_req(int ins_w, int del_w);
    route_req_t rq;
    route_key_t k;
    int         pick;
    bit [127:0] base;
    pick = $urandom_range(0, 99);
    base = prefix_base[$urandom_range(0, 7)];
    rq   = route_req(OP_LOOKUP, '0, pick_len(), rand_addr(), $urandom);
    if (pick < ins_w) begin
      rq.op = OP_INSERT;
      {rq.addr_hi, rq.addr_lo} = under_prefix(base, rq.len);
      k.a = {rq.addr_hi, rq.addr_lo};
      k.l = rq.len;
      route_pool.insert(route_pool.size(), k);
      if (route_pool.size() > 200) void'(route_pool.pop_front());
    end else if (pick < ins_w + del_w) begin
      rq.op = OP_DELETE;
      if (route_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = route_pool[$urandom_range(0, route_pool.size() - 1)];
        rq.len = k.l;
        {rq.addr_hi, rq.addr_lo} = under_prefix(k.a, k.l);
      end else begin
        {rq.addr_hi, rq.addr_lo} = under_prefix(base, rq.len);
      end
    end else if (pick < 82) begin
      rq.op = OP_LOOKUP;
      {rq.addr_hi, rq.addr_lo} = under_prefix(base, 8'($urandom_range(0, 128)));
    end else if (pick < 94) begin
      rq.op = OP_QUERY;
      if (route_pool.size() > 0 && $urandom_range(0, 3) != 0) begin
        k = route_pool[$urandom_range(0, route_pool.size() - 1)];
        rq.len = k.l;
        {rq.addr_hi, rq.addr_lo} = ($urandom_range(0, 2) != 0) ? k.a : under_prefix(k.a, k.l);
      end else begin
        {rq.addr_hi, rq.addr_lo} = under_prefix(base, rq.len);
      end
    end else begin
      rq.op = req_op_t'($urandom_range(0, 3));
      {rq.addr_hi, rq.addr_lo} = rand_addr();
      rq.len = 8'($urandom_range(0, 255));
    end
    return rq;
  endfunction

  task automatic send_request(route_req_t rq);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= rq.op;
    req_bus.addr_hi    <= rq.addr_hi;
    req_bus.addr_lo    <= rq.addr_lo;
    req_bus.pfx_len    <= rq.len;
    req_bus.nexthop_hi <= rq.nh_hi;
    req_bus.nexthop_lo <= rq.nh_lo;
    req_bus.intf_id    <= rq.port;
    do @(posedge clk); while (!req_bus.ready);
    route_sb.note_request(rq);
  endtask

  // result side: random stalls while idle_on is set, then take one word and check it
  initial begin
    int         stall;
    route_rsp_t got;
    rsp_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      got.found      = rsp_bus.found;
      got.table_full = rsp_bus.table_full;
      got.addr_hi    = rsp_bus.out_addr_hi;
      got.addr_lo    = rsp_bus.out_addr_lo;
      got.len        = rsp_bus.out_pfx_len;
      got.nh_hi      = rsp_bus.out_nexthop_hi;
      got.nh_lo      = rsp_bus.out_nexthop_lo;
      got.port       = rsp_bus.out_intf_id;
      route_sb.check_result(got);
    end
  end

  initial begin
    bit [127:0] ones;
    bit [127:0] pfx;
    int         ins_w;
    int         del_w;
    ones = {128{1'b1}};
    pfx  = {64'h2001_0db8_0000_0000, rand_addr()};
    rst                <= 1'b1;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= OP_INSERT;
    req_bus.addr_hi    <= '0;
    req_bus.addr_lo    <= '0;
    req_bus.pfx_len    <= '0;
    req_bus.nexthop_hi <= '0;
    req_bus.nexthop_lo <= '0;
    req_bus.intf_id    <= '0;
    foreach (prefix_base[i]) prefix_base[i] = rand_addr();
    prefix_base[0] = '0;
    prefix_base[1] = ones;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table, then default route, host routes and length saturation
    send_request(route_req(OP_LOOKUP, rand_addr(), 8'd0, '0, '0));
    send_request(route_req(OP_QUERY, '0, 8'd0, '0, '0));
    send_request(route_req(OP_DELETE, ones, 8'd128, '0, '0));
    send_request(route_req(OP_INSERT, ones, 8'd0, ones, '1));
    send_request(route_req(OP_LOOKUP, '0, 8'd0, '0, '0));
    send_request(route_req(OP_QUERY, ones, 8'd0, '0, '0));
    send_request(route_req(OP_INSERT, ones, 8'd128, '0, '0));
    send_request(route_req(OP_LOOKUP, ones, 8'd0, '0, '0));
    send_request(route_req(OP_INSERT, '0, 8'd255, rand_addr(), $urandom));
    send_request(route_req(OP_QUERY, '0, 8'd200, '0, '0));
    // nested prefixes, replace with different tail bits, masked delete
    send_request(route_req(OP_INSERT, pfx, 8'd64, rand_addr(), $urandom));
    send_request(route_req(OP_INSERT, pfx, 8'd48, rand_addr(), $urandom));
    send_request(route_req(OP_LOOKUP, under_prefix(pfx, 8'd64), 8'd0, '0, '0));
    send_request(route_req(OP_INSERT, under_prefix(pfx, 8'd64), 8'd64, rand_addr(), $urandom));
    send_request(route_req(OP_QUERY, pfx, 8'd64, '0, '0));
    send_request(route_req(OP_LOOKUP, under_prefix(pfx, 8'd50), 8'd0, '0, '0));
    send_request(route_req(OP_DELETE, under_prefix(pfx, 8'd64), 8'd64, '0, '0));
    send_request(route_req(OP_LOOKUP, under_prefix(pfx, 8'd64), 8'd0, '0, '0));
    send_request(route_req(OP_DELETE, under_prefix(pfx, 8'd48), 8'd48, '0, '0));
    send_request(route_req(OP_DELETE, '0, 8'd0, '0, '0));
    send_request(route_req(OP_LOOKUP, rand_addr(), 8'd0, '0, '0));
    send_request(route_req(OP_INSERT, {1'b1, 127'd0}, 8'd1, rand_addr(), $urandom));
    send_request(route_req(OP_LOOKUP, {1'b1, 127'd5}, 8'd0, '0, '0));
    send_request(route_req(OP_LOOKUP, {1'b0, {127{1'b1}}}, 8'd0, '0, '0));
    send_request(route_req(OP_QUERY, ones, 8'd129, '0, '0));

    // alternate fill-heavy and drain-heavy phases; every third phase runs flat out
    for (int phase = 0; phase < PHASES; phase++) begin
      idle_on = (phase % 3 != 2);
      ins_w   = (phase % 2 == 0) ? 60 : 20;
      del_w   = (phase % 2 == 0) ? 3 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(make_route_req(ins_w, del_w));
    end
    req_bus.valid <= 1'b0;

    while (route_sb.pending() != 0) @(posedge clk);
    repeat (2 * (TABLE_DEPTH + 3)) @(posedge clk);
    if (route_sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
